[sv/seconds_to_calendar_date_defines.svh]
// assertion macros for the seconds to calendar date checker
`ifndef SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define SCD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/scd_pkg.sv]
// shared types and constants for the seconds to calendar date converter
package scd_pkg;

  localparam int CNT_W = 5;

  localparam logic signed [38:0] MIN_COUNT = -39'sd63113904000;
  localparam logic signed [38:0] MAX_COUNT = 39'sd252423993599;

  localparam int DAY_QBITS  = 22;
  localparam int CYC_QBITS  = 5;
  localparam int QUAD_QBITS = 5;
  localparam int HOUR_QBITS = 5;
  localparam int MIN_QBITS  = 6;

  localparam int CEN_MAX = 3;
  localparam int YRS_MAX = 3;
  localparam int MON_MAX = 11;

  typedef enum logic [2:0] {
    PH_DAYS,
    PH_CYC,
    PH_CEN,
    PH_QUAD,
    PH_YRS,
    PH_MON,
    PH_HOUR,
    PH_MINS
  } ph_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAYS,
    ST_CYC,
    ST_CEN,
    ST_QUAD,
    ST_YRS,
    ST_MON,
    ST_HOUR,
    ST_MINS,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             last;
    logic             emit;
    ph_t              ph;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic ge;
    logic bad;
  } stat_t;

endpackage

[sv/scd_ctrl.sv]
// sequencer for the conversion phases
module scd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  scd_pkg::stat_t stat,
  output scd_pkg::cmd_t  cmd,
  output logic           busy
);

  scd_pkg::st_t state_r, state_nxt;
  logic [scd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // end of the current phase
  always_comb begin
    case (state_r)
      scd_pkg::ST_CEN:
        fin = !stat.ge || (cnt_r == scd_pkg::CNT_W'(scd_pkg::CEN_MAX - 1));
      scd_pkg::ST_YRS:
        fin = !stat.ge || (cnt_r == scd_pkg::CNT_W'(scd_pkg::YRS_MAX - 1));
      scd_pkg::ST_MON:
        fin = !stat.ge || (cnt_r == scd_pkg::CNT_W'(scd_pkg::MON_MAX - 1));
      default:
        fin = (cnt_r == '0);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      scd_pkg::ST_IDLE: begin
        if (start) begin
          if (stat.bad) begin
            state_nxt = scd_pkg::ST_DONE;
          end else begin
            state_nxt = scd_pkg::ST_DAYS;
            cnt_nxt   = scd_pkg::CNT_W'(scd_pkg::DAY_QBITS - 1);
          end
        end
      end
      scd_pkg::ST_DAYS: begin
        cnt_nxt = cnt_r - 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_CYC;
          cnt_nxt   = scd_pkg::CNT_W'(scd_pkg::CYC_QBITS - 1);
        end
      end
      scd_pkg::ST_CYC: begin
        cnt_nxt = cnt_r - 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_CEN;
          cnt_nxt   = '0;
        end
      end
      scd_pkg::ST_CEN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_QUAD;
          cnt_nxt   = scd_pkg::CNT_W'(scd_pkg::QUAD_QBITS - 1);
        end
      end
      scd_pkg::ST_QUAD: begin
        cnt_nxt = cnt_r - 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_YRS;
          cnt_nxt   = '0;
        end
      end
      scd_pkg::ST_YRS: begin
        cnt_nxt = cnt_r + 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_MON;
          cnt_nxt   = '0;
        end
      end
      scd_pkg::ST_MON: begin
        cnt_nxt = cnt_r + 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_HOUR;
          cnt_nxt   = scd_pkg::CNT_W'(scd_pkg::HOUR_QBITS - 1);
        end
      end
      scd_pkg::ST_HOUR: begin
        cnt_nxt = cnt_r - 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_MINS;
          cnt_nxt   = scd_pkg::CNT_W'(scd_pkg::MIN_QBITS - 1);
        end
      end
      scd_pkg::ST_MINS: begin
        cnt_nxt = cnt_r - 1'b1;
        if (fin) begin
          state_nxt = scd_pkg::ST_DONE;
          cnt_nxt   = '0;
        end
      end
      scd_pkg::ST_DONE: begin
        state_nxt = scd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = scd_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    cmd.last = fin;
    cmd.emit = 1'b0;
    cmd.ph   = scd_pkg::PH_DAYS;
    cmd.idx  = cnt_r;
    busy     = 1'b1;
    case (state_r)
      scd_pkg::ST_IDLE: begin
        cmd.load = start;
        busy     = 1'b0;
      end
      scd_pkg::ST_DAYS: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_DAYS;
      end
      scd_pkg::ST_CYC: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_CYC;
      end
      scd_pkg::ST_CEN: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_CEN;
      end
      scd_pkg::ST_QUAD: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_QUAD;
      end
      scd_pkg::ST_YRS: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_YRS;
      end
      scd_pkg::ST_MON: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_MON;
      end
      scd_pkg::ST_HOUR: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_HOUR;
      end
      scd_pkg::ST_MINS: begin
        cmd.step = 1'b1;
        cmd.ph   = scd_pkg::PH_MINS;
      end
      scd_pkg::ST_DONE: begin
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[sv/scd_dp.sv]
// shared compare and subtract datapath with the result registers
module scd_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scd_pkg::cmd_t        cmd,
  output scd_pkg::stat_t       stat,
  input  logic signed [38:0]   in_count_seconds,
  output logic                 out_strobe,
  output logic                 out_status,
  output logic [13:0]          out_year,
  output logic [3:0]           out_month,
  output logic [4:0]           out_day_of_month,
  output logic [4:0]           out_hour,
  output logic [5:0]           out_minute,
  output logic [5:0]           out_second
);

  localparam logic [38:0] SECS_PER_DAY     = 39'd86400;
  localparam logic [38:0] DAYS_PER_CYCLE   = 39'd146097;
  localparam logic [38:0] DAYS_PER_CENT    = 39'd36524;
  localparam logic [38:0] DAYS_PER_QUAD    = 39'd1461;
  localparam logic [38:0] COMMON_YEAR_DAYS = 39'd365;
  localparam logic [38:0] SECS_PER_HOUR    = 39'd3600;
  localparam logic [38:0] SECS_PER_MIN     = 39'd60;
  localparam logic [13:0] YEARS_CYCLE      = 14'd400;
  localparam logic [13:0] YEARS_CENT       = 14'd100;
  localparam logic [13:0] YEARS_QUAD       = 14'd4;
  localparam int          QW               = scd_pkg::DAY_QBITS;

  function automatic logic [4:0] month_len(logic leap, logic [3:0] m);
    case (m)
      4'd1:                      month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [38:0] div_den(scd_pkg::ph_t ph,
                                          logic [scd_pkg::CNT_W-1:0] idx,
                                          logic [4:0] mlen);
    case (ph)
      scd_pkg::PH_DAYS: div_den = SECS_PER_DAY << idx;
      scd_pkg::PH_CYC:  div_den = DAYS_PER_CYCLE << idx;
      scd_pkg::PH_CEN:  div_den = DAYS_PER_CENT;
      scd_pkg::PH_QUAD: div_den = DAYS_PER_QUAD << idx;
      scd_pkg::PH_YRS:  div_den = COMMON_YEAR_DAYS;
      scd_pkg::PH_MON:  div_den = 39'(mlen);
      scd_pkg::PH_HOUR: div_den = SECS_PER_HOUR << idx;
      scd_pkg::PH_MINS: div_den = SECS_PER_MIN << idx;
      default:          div_den = '0;
    endcase
  endfunction

  function automatic logic [13:0] year_wt(scd_pkg::ph_t ph,
                                          logic [scd_pkg::CNT_W-1:0] idx);
    case (ph)
      scd_pkg::PH_CYC:  year_wt = YEARS_CYCLE << idx;
      scd_pkg::PH_CEN:  year_wt = YEARS_CENT;
      scd_pkg::PH_QUAD: year_wt = YEARS_QUAD << idx;
      scd_pkg::PH_YRS:  year_wt = 14'd1;
      default:          year_wt = '0;
    endcase
  endfunction

  logic [38:0]   num_r, num_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [13:0]   year_r;
  logic [16:0]   tod_r;
  logic [1:0]    cen_r;
  logic [1:0]    yc_r;
  logic          quad24_r;
  logic [3:0]    mon_r;
  logic [4:0]    day_r;
  logic [4:0]    hour_r;
  logic [5:0]    minute_r;
  logic [5:0]    second_r;
  logic          bad_r;

  logic [38:0]   den;
  logic [38:0]   num_step;
  logic          ge;
  logic          take;
  logic          leap;
  logic [4:0]    mlen;

  assign leap = (yc_r == 2'd3) && (!quad24_r || (cen_r == 2'd3));
  assign mlen = month_len(leap, mon_r);
  assign den  = div_den(cmd.ph, cmd.idx, mlen);
  assign ge   = (num_r >= den);
  assign take = cmd.step && ge;
  assign num_step = take ? (num_r - den) : num_r;
  assign quo_nxt  = {quo_r[QW-2:0], ge};

  assign stat.ge  = ge;
  assign stat.bad = (in_count_seconds < scd_pkg::MIN_COUNT) ||
                    (in_count_seconds > scd_pkg::MAX_COUNT);

  always_comb begin
    num_nxt = num_step;
    if (cmd.last && (cmd.ph == scd_pkg::PH_DAYS)) begin
      num_nxt = 39'(quo_nxt);
    end else if (cmd.last && (cmd.ph == scd_pkg::PH_MON)) begin
      num_nxt = 39'(tod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r  <= $unsigned(in_count_seconds - scd_pkg::MIN_COUNT);
      bad_r  <= stat.bad;
      year_r <= 14'd1;
      quo_r  <= '0;
      cen_r  <= '0;
      yc_r   <= '0;
      mon_r  <= '0;
    end else if (cmd.step) begin
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      if (take) begin
        year_r <= year_r + year_wt(cmd.ph, cmd.idx);
      end
      case (cmd.ph)
        scd_pkg::PH_DAYS: begin
          if (cmd.last) begin
            tod_r <= num_step[16:0];
            quo_r <= '0;
          end
        end
        scd_pkg::PH_CEN: begin
          if (take) begin
            cen_r <= cen_r + 2'd1;
          end
        end
        scd_pkg::PH_QUAD: begin
          if (cmd.last) begin
            quad24_r <= (quo_nxt[4:0] == 5'd24);
          end
        end
        scd_pkg::PH_YRS: begin
          if (take) begin
            yc_r <= yc_r + 2'd1;
          end
        end
        scd_pkg::PH_MON: begin
          if (take) begin
            mon_r <= mon_r + 4'd1;
          end
          if (cmd.last) begin
            day_r <= num_step[4:0];
          end
        end
        scd_pkg::PH_HOUR: begin
          if (cmd.last) begin
            hour_r <= quo_nxt[4:0];
          end
        end
        scd_pkg::PH_MINS: begin
          if (cmd.last) begin
            minute_r <= quo_nxt[5:0];
            second_r <= num_step[5:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status       <= bad_r;
      out_year         <= bad_r ? 14'd0 : year_r;
      out_month        <= bad_r ? 4'd0 : mon_r + 4'd1;
      out_day_of_month <= bad_r ? 5'd0 : day_r + 5'd1;
      out_hour         <= bad_r ? 5'd0 : hour_r;
      out_minute       <= bad_r ? 6'd0 : minute_r;
      out_second       <= bad_r ? 6'd0 : second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
    end
  end

endmodule

[sv/seconds_to_calendar_date.sv]
// one compare and subtract unit retires one quotient bit or one century, year or month
// step per cycle (22 bits for days, then 1 to 11 steps per field); an out-of-range count
// skips the phases and goes straight to the result beat
// a new count is taken only while busy is low; busy drops as the strobe rises
// results are not held off by the receiver; out_strobe marks each result for one cycle only
// reset: synchronous active-low rst_n returns the sequencer to idle and clears the strobe
module seconds_to_calendar_date (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [38:0] in_count_seconds,
  output logic               out_strobe,
  output logic               out_status,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);

  scd_pkg::cmd_t  cmd;
  scd_pkg::stat_t stat;

  scd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  scd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_count_seconds (in_count_seconds),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

endmodule

[sv/scd_checker.sv]
// port level checks for the seconds to calendar date converter
`include "seconds_to_calendar_date_defines.svh"

module scd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [38:0] in_count_seconds,
  input logic               out_strobe,
  input logic               out_status,
  input logic [13:0]        out_year,
  input logic [3:0]         out_month,
  input logic [4:0]         out_day_of_month,
  input logic [4:0]         out_hour,
  input logic [5:0]         out_minute,
  input logic [5:0]         out_second
);

  logic bad_beat;
  logic good_beat;
  logic zero_fields;
  logic good_fields;

  assign bad_beat    = out_strobe && out_status;
  assign good_beat   = out_strobe && !out_status;
  assign zero_fields = (out_year == 14'd0) && (out_month == 4'd0) &&
                       (out_day_of_month == 5'd0) && (out_hour == 5'd0) &&
                       (out_minute == 6'd0) && (out_second == 6'd0);
  assign good_fields = (out_month >= 4'd1) && (out_month <= 4'd12) &&
                       (out_day_of_month >= 5'd1) && (out_hour <= 5'd23) &&
                       (out_minute <= 6'd59) && (out_second <= 6'd59);

  `SCD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy low after accept")

  `SCD_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "strobe too long")

  `SCD_ASSERT_SAME(a_done_strobe, clk, rst_n, $fell(busy) && $past(rst_n), out_strobe, "no beat")

  `SCD_ASSERT_SAME(a_bad_zero, clk, rst_n, bad_beat, zero_fields, "nonzero invalid beat")

  `SCD_ASSERT_SAME(a_good_range, clk, rst_n, good_beat, good_fields, "valid field out of range")

endmodule

bind seconds_to_calendar_date scd_checker u_scd_checker (.*);
